/* design/dtw_pkg.sv */
`default_nettype none

package dtw_pkg;

    // Width of the word position counter and of the reported positions
    localparam int POS_BITS = 20;

    // Width of one structure block word
    localparam int WORD_BITS = 32;

    // Result payload: node_name_pos, prop_name_offset, prop_length, value_pos
    localparam int OUT_FIELD_BITS = POS_BITS + WORD_BITS + WORD_BITS + POS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Result kind carried on m_tuser
    localparam logic KIND_PROP = 1'b0;
    localparam logic KIND_END  = 1'b1;

endpackage

`default_nettype wire

/* design/devicetree_structure_walker.sv */
// Channel  | Direction | Payload                                      | Handshake
// ---------+-----------+----------------------------------------------+-----------------
// s_axis   | in        | tdata: word[31:0]                            | tvalid / tready
// m_axis   | out       | tdata: node_name_pos, prop_name_offset,      | tvalid / tready
//          |           |   prop_length, value_pos; tuser: kind        |
//
// One word is taken per cycle while no stalled result holds the output register;
// a result appears on m_axis in the cycle after the word that causes it. Reset
// puts the walker in the expect-token phase at position zero. A stalled result
// holds in the output register; a new word is still taken while the held result
// leaves in the same cycle.
`default_nettype none

module devicetree_structure_walker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dtw_pkg::WORD_BITS-1:0]    s_tdata,   // word[31:0]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // node_name_pos[19:0], prop_name_offset[51:20], prop_length[83:52],
    // value_pos[103:84]
    output logic [dtw_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
    output logic                                  m_tuser    // kind[0]
);

    // Token codes
    localparam logic [dtw_pkg::WORD_BITS-1:0] TOKEN_BEGIN_NODE = 32'd1;
    localparam logic [dtw_pkg::WORD_BITS-1:0] TOKEN_PROP       = 32'd3;
    localparam logic [dtw_pkg::WORD_BITS-1:0] TOKEN_END        = 32'd9;

    // Phase codes
    localparam logic [2:0] PH_TOKEN   = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_NAMEOFF = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;

    localparam int SKIP_BITS = dtw_pkg::WORD_BITS - 2;
    localparam logic [dtw_pkg::POS_BITS-1:0] POS_MAX = '1;

    logic [2:0]                       phase_reg, phase_next;
    logic [dtw_pkg::POS_BITS-1:0]     word_pos_reg, word_pos_next;
    logic [SKIP_BITS-1:0]             skip_reg, skip_next;
    logic [dtw_pkg::POS_BITS-1:0]     node_pos_reg, node_pos_next;
    logic [dtw_pkg::WORD_BITS-1:0]    length_reg, length_next;
    logic                             finished_reg, finished_next;

    logic                             out_valid_reg;
    logic                             out_kind_reg;
    logic [dtw_pkg::OUT_FIELD_BITS-1:0] out_data_reg;

    logic                             s_fire;
    logic                             emit;
    logic                             emit_kind;
    logic [dtw_pkg::OUT_FIELD_BITS-1:0] emit_data;
    logic [dtw_pkg::POS_BITS-1:0]     pos_inc;
    logic                             zero_byte;
    logic [SKIP_BITS:0]               value_words;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = dtw_pkg::OUT_TDATA_BITS'(out_data_reg);

    // Saturating position of the word after this one
    assign pos_inc = (word_pos_reg == POS_MAX) ? POS_MAX : word_pos_reg + 1'b1;

    assign zero_byte = (s_tdata[7:0] == 8'd0) || (s_tdata[15:8] == 8'd0) ||
                       (s_tdata[23:16] == 8'd0) || (s_tdata[31:24] == 8'd0);

    // Value words, rounded up to whole words
    assign value_words = (SKIP_BITS + 1)'(length_reg[dtw_pkg::WORD_BITS-1:2])
                       + (SKIP_BITS + 1)'(length_reg[1:0] != 2'd0);

    // Decode the token phase for the incoming word
    always_comb
    begin
        phase_next    = phase_reg;
        word_pos_next = word_pos_reg;
        skip_next     = skip_reg;
        node_pos_next = node_pos_reg;
        length_next   = length_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        emit_kind     = dtw_pkg::KIND_PROP;
        emit_data     = '0;

        if (s_fire && !finished_reg)
        begin
            word_pos_next = pos_inc;
            case (phase_reg)
                PH_TOKEN:
                begin
                    if (s_tdata == TOKEN_BEGIN_NODE)
                    begin
                        node_pos_next = pos_inc;
                        phase_next    = PH_NAME;
                    end
                    else if (s_tdata == TOKEN_PROP)
                    begin
                        phase_next = PH_LEN;
                    end
                    else if (s_tdata == TOKEN_END)
                    begin
                        emit          = 1'b1;
                        emit_kind     = dtw_pkg::KIND_END;
                        finished_next = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    if (zero_byte)
                        phase_next = PH_TOKEN;
                end
                PH_LEN:
                begin
                    length_next = s_tdata;
                    phase_next  = PH_NAMEOFF;
                end
                PH_NAMEOFF:
                begin
                    emit      = 1'b1;
                    emit_kind = dtw_pkg::KIND_PROP;
                    emit_data = {pos_inc, length_reg, s_tdata, node_pos_reg};
                    if (value_words == '0)
                    begin
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        skip_next  = SKIP_BITS'(value_words - 1'b1);
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (skip_reg == '0)
                        phase_next = PH_TOKEN;
                    else
                        skip_next = skip_reg - 1'b1;
                end
                default:
                begin
                    phase_next = PH_TOKEN;
                end
            endcase
        end
    end

    // Advance walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOKEN;
            word_pos_reg <= '0;
            skip_reg     <= '0;
            node_pos_reg <= '0;
            length_reg   <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            word_pos_reg <= word_pos_next;
            skip_reg     <= skip_next;
            node_pos_reg <= node_pos_next;
            length_reg   <= length_next;
            finished_reg <= finished_next;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_data_reg <= emit_data;
        end
    end

endmodule

`default_nettype wire

/* design/dtw_checker.sv */
`default_nettype none

module dtw_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [dtw_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input wire logic                             m_tuser
);

    logic end_seen_reg;
    logic m_fire;

    assign m_fire = m_tvalid && m_tready;

    // Track that the end result has left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_seen_reg <= 1'b0;
        else if (m_fire && (m_tuser == dtw_pkg::KIND_END))
            end_seen_reg <= 1'b1;
    end

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // Nothing follows the end result
    assert property (@(posedge clk) disable iff (!rst_n)
        end_seen_reg |-> !m_fire)
    else $error("result after end");

    // End result carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dtw_pkg::KIND_END) |-> (m_tdata == '0))
    else $error("end result payload not zero");

    // Value position never precedes the node position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dtw_pkg::KIND_PROP) |->
            m_tdata[dtw_pkg::OUT_FIELD_BITS-1:dtw_pkg::OUT_FIELD_BITS-dtw_pkg::POS_BITS]
            >= m_tdata[dtw_pkg::POS_BITS-1:0])
    else $error("value position below node position");

    // Input never stalls while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind devicetree_structure_walker dtw_checker u_dtw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
